>>> rtl/bbra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbra_pkg
// Shared codes and controller/datapath interface types for the block run
// allocator.
// ----------------------------------------------------------------------------
package bbra_pkg;

  localparam int unsigned StatusWidth = 2;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_INDEX = 2'd1;
  localparam logic [StatusWidth-1:0] ST_START = 2'd2;
  localparam logic [StatusWidth-1:0] ST_SHORT = 2'd3;

  localparam logic REQ_MARK  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef struct packed {
    logic                   clear;
    logic                   latch;
    logic                   mark_idx;
    logic                   rd_start;
    logic                   scan_init;
    logic                   scan;
    logic                   emit_final;
    logic [StatusWidth-1:0] final_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_bad;
    logic start_bad;
    logic scan_done;
    logic slot_free;
    logic cnt_eq_len;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/bbra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbra_ctrl
// Sequencer for the allocator: clearing pass, mark, index claim, start check,
// scan and final status.
// ----------------------------------------------------------------------------
module bbra_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire logic          req_type_i,
  input  wire bbra_pkg::sts_t sts_i,
  output bbra_pkg::cmd_t     cmd_o
);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_MARK     = 11'b000_0000_0100,
    S_IDX_RD   = 11'b000_0000_1000,
    S_IDX_CHK  = 11'b000_0001_0000,
    S_ST_RD    = 11'b000_0010_0000,
    S_ST_CHK   = 11'b000_0100_0000,
    S_SCAN     = 11'b000_1000_0000,
    S_FIN_IDX  = 11'b001_0000_0000,
    S_FIN_ST   = 11'b010_0000_0000,
    S_FIN_SCAN = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = (req_type_i == bbra_pkg::REQ_ALLOC) ? S_IDX_RD : S_MARK;
        end
      end
      S_MARK: begin
        cmd_o.mark_idx = 1'b1;
        state_d = S_IDLE;
      end
      S_IDX_RD: begin
        state_d = S_IDX_CHK;
      end
      S_IDX_CHK: begin
        if (sts_i.idx_bad) begin
          state_d = S_FIN_IDX;
        end else begin
          cmd_o.mark_idx = 1'b1;
          state_d = S_ST_RD;
        end
      end
      S_ST_RD: begin
        cmd_o.rd_start = 1'b1;
        state_d = S_ST_CHK;
      end
      S_ST_CHK: begin
        if (sts_i.start_bad) begin
          state_d = S_FIN_ST;
        end else begin
          cmd_o.rd_start  = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_FIN_SCAN;
      end
      S_FIN_IDX: begin
        cmd_o.final_status = bbra_pkg::ST_INDEX;
        if (sts_i.slot_free) begin
          cmd_o.emit_final = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN_ST: begin
        cmd_o.final_status = bbra_pkg::ST_START;
        if (sts_i.slot_free) begin
          cmd_o.emit_final = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN_SCAN: begin
        cmd_o.final_status = sts_i.cnt_eq_len ? bbra_pkg::ST_OK : bbra_pkg::ST_SHORT;
        if (sts_i.slot_free) begin
          cmd_o.emit_final = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bbra_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbra_dpath
// Occupancy bitmap memory, request registers, scan pointer and count, and
// the output register.
// ----------------------------------------------------------------------------
module bbra_dpath #(
  parameter int unsigned NUM_BLOCKS = 128,
  parameter int unsigned MAX_RUN    = 32,
  localparam int unsigned BlkW      = $clog2(NUM_BLOCKS),
  localparam int unsigned LenW      = $clog2(MAX_RUN + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bbra_pkg::cmd_t               cmd_i,
  output bbra_pkg::sts_t                    sts_o,
  input  wire logic [BlkW-1:0]              index_block_i,
  input  wire logic [BlkW-1:0]              start_block_i,
  input  wire logic [LenW-1:0]              run_length_i,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  output logic [BlkW-1:0]                   block_number_o,
  output logic [LenW-1:0]                   position_o,
  output logic [bbra_pkg::StatusWidth-1:0]  status_o,
  output logic                              last_o
);

  localparam logic [BlkW:0]   NumBlocksW = (BlkW + 1)'(NUM_BLOCKS);
  localparam logic [BlkW-1:0] LastBlock  = BlkW'(NUM_BLOCKS - 1);
  localparam logic [LenW-1:0] MaxRunW    = LenW'(MAX_RUN);

  logic                  mem_q [NUM_BLOCKS];
  logic                  rd_data_q;
  logic [BlkW-1:0]       rd_addr;
  logic                  wr_en;
  logic [BlkW-1:0]       wr_addr;
  logic                  wr_data;

  logic [BlkW-1:0]       clr_q;
  logic [BlkW-1:0]       idx_q, start_q, pos_q, pos_d, pos_nx;
  logic [LenW-1:0]       len_q, cnt_q, cnt_d, cnt_nx;
  logic                  idx_oor, start_oor;
  logic                  take, advance;

  logic                  out_valid_q;
  logic [BlkW-1:0]       out_blk_q;
  logic [LenW-1:0]       out_pos_q;
  logic [bbra_pkg::StatusWidth-1:0] out_st_q;
  logic                  out_last_q;
  logic                  slot_free;
  logic                  load;

  assign idx_oor   = {1'b0, idx_q} >= NumBlocksW;
  assign start_oor = {1'b0, start_q} >= NumBlocksW;
  assign slot_free = !out_valid_q || rsp_ready_i;

  // scan step
  assign take    = cmd_i.scan && !rd_data_q && slot_free;
  assign advance = rd_data_q || slot_free;
  assign pos_nx  = (pos_q == LastBlock) ? '0 : pos_q + BlkW'(1);
  assign cnt_nx  = cnt_q + LenW'(take);
  assign load    = take || cmd_i.emit_final;

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (cmd_i.scan_init) begin
      pos_d = start_q;
      cnt_d = '0;
    end else if (cmd_i.scan) begin
      cnt_d = cnt_nx;
      if (advance) pos_d = pos_nx;
    end
  end

  always_comb begin
    if (cmd_i.scan) begin
      rd_addr = advance ? pos_nx : pos_q;
    end else if (cmd_i.rd_start) begin
      rd_addr = start_q;
    end else begin
      rd_addr = idx_q;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = 1'b1;
    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = 1'b0;
    end else if (cmd_i.mark_idx) begin
      wr_en = !idx_oor;
    end else if (take) begin
      wr_en   = 1'b1;
      wr_addr = pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + BlkW'(1);
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q   <= index_block_i;
      start_q <= start_block_i;
      len_q   <= (run_length_i > MaxRunW) ? MaxRunW : run_length_i;
    end
    pos_q <= pos_d;
    cnt_q <= cnt_d;
    if (take) begin
      out_blk_q  <= pos_q;
      out_pos_q  <= cnt_q;
      out_st_q   <= bbra_pkg::ST_OK;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_final) begin
      out_blk_q  <= idx_q;
      out_pos_q  <= cnt_q;
      out_st_q   <= cmd_i.final_status;
      out_last_q <= 1'b1;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = clr_q == LastBlock;
    sts_o.idx_bad    = idx_oor || rd_data_q;
    sts_o.start_bad  = start_oor || rd_data_q;
    sts_o.scan_done  = advance && ((pos_nx == start_q) || (cnt_nx >= len_q));
    sts_o.slot_free  = slot_free;
    sts_o.cnt_eq_len = cnt_q == len_q;
  end

  assign rsp_valid_o    = out_valid_q;
  assign block_number_o = out_blk_q;
  // position reads zero on index and start failures
  assign position_o     = (out_last_q && out_st_q != bbra_pkg::ST_OK &&
                           out_st_q != bbra_pkg::ST_SHORT) ? '0 : out_pos_q;
  assign status_o       = out_st_q;
  assign last_o         = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_ready_i) |-> !load)
    else $error("output register overwritten while pending");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (cnt_q <= len_q))
    else $error("scan count above run length");

  a_scan_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && wr_en) |-> (wr_addr == pos_q && wr_data && load))
    else $error("scan write without a claimed block");

endmodule
`default_nettype wire

>>> rtl/bitmap_block_run_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_run_allocator
// Occupancy bitmap with mark and indexed run allocation requests.
// ----------------------------------------------------------------------------
// Request channel (req_*): a mark request sets one block occupied and gives
// no response; an allocate request claims the index block, then scans from
// the start block with wraparound, returning one response per claimed data
// block and a final status response with last_o set.
// Response channel (rsp_*): valid/ready through an output register.
// A mark request sets its block occupied and returns to idle. An allocate
// request checks the index and start blocks, then scans (the bitmap memory
// has one read and one write port and is walked one entry a cycle unless
// the scan holds as described below), then emits the status.
// The next request is taken once the final status sits in the output
// register. While the output register holds a response that rsp_ready_i
// has not yet taken, the scan holds on the block it has found free until
// the output register can take it. After reset the bitmap memory is cleared
// one entry a cycle; req_ready_o stays low until every entry is cleared.
// ----------------------------------------------------------------------------
module bitmap_block_run_allocator #(
  parameter int unsigned NUM_BLOCKS = 128,
  parameter int unsigned MAX_RUN    = 32,
  localparam int unsigned BlkW      = $clog2(NUM_BLOCKS),
  localparam int unsigned LenW      = $clog2(MAX_RUN + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  output logic                             req_ready_o,
  input  wire logic                        req_type_i,
  input  wire logic [BlkW-1:0]             index_block_i,
  input  wire logic [BlkW-1:0]             start_block_i,
  input  wire logic [LenW-1:0]             run_length_i,
  output logic                             rsp_valid_o,
  input  wire logic                        rsp_ready_i,
  output logic [BlkW-1:0]                  block_number_o,
  output logic [LenW-1:0]                  position_o,
  output logic [bbra_pkg::StatusWidth-1:0] status_o,
  output logic                             last_o
);

  bbra_pkg::cmd_t cmd;
  bbra_pkg::sts_t sts;

  bbra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_type_i  (req_type_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bbra_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_RUN    (MAX_RUN)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .index_block_i  (index_block_i),
    .start_block_i  (start_block_i),
    .run_length_i   (run_length_i),
    .rsp_valid_o    (rsp_valid_o),
    .rsp_ready_i    (rsp_ready_i),
    .block_number_o (block_number_o),
    .position_o     (position_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
